// ----- rtl/bocc_pkg.sv -----
// ============================================================================
// bocc_pkg: shared types and constants for the occupancy update block
// Fixed-point formats, item structures, mode codes, register indexes and the
// rounding multiply used by the Bayes occupancy update pipeline.
// ============================================================================
`default_nettype none

package bocc_pkg;

    // Probabilities are unsigned fixed point with PROB_FRAC_BITS fraction bits.
    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1 << PROB_FRAC_BITS);
    localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(1 << (PROB_FRAC_BITS - 1));

    // Numerator holds two terms, denominator three, each at most one.
    localparam int NUM_W  = PROB_W + 1;
    localparam int DEN_W  = PROB_W + 2;
    // Dividend is (num << F) + den / 2.
    localparam int DIVD_W = NUM_W + PROB_FRAC_BITS;
    // The rounded quotient never exceeds one, so it fits in PROB_W bits.
    localparam int QUO_W  = PROB_W;
    localparam int DIV_LAT = QUO_W;

    // Blend products and their rounded sum.
    localparam int PROD_W  = 2 * PROB_W;
    localparam int BSUM_W  = PROD_W + 1;
    localparam int BRES_W  = BSUM_W - PROB_FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_IF_OCCUPIED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_IF_FREE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_IF_HIDDEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH      = 3'd4;

    // Register reset values.
    localparam logic [PROB_W-1:0] RST_HIT_IF_OCCUPIED = 17'd45875;
    localparam logic [PROB_W-1:0] RST_HIT_IF_FREE     = 17'd26214;
    localparam logic [PROB_W-1:0] RST_HIT_IF_HIDDEN   = 17'd32768;
    localparam logic [PROB_W-1:0] RST_CLAMP_LOW       = 17'd7864;
    localparam logic [PROB_W-1:0] RST_CLAMP_HIGH      = 17'd63570;

    // Update modes, chosen by the measured factor.
    localparam logic [1:0] MODE_MISS  = 2'd0;
    localparam logic [1:0] MODE_HIT   = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;

    typedef struct packed {
        logic [PROB_W-1:0] prior_occupancy;
        logic [PROB_W-1:0] visibility;
        logic [PROB_W-1:0] measured_factor;
    } in_item_t;

    typedef struct packed {
        logic [PROB_W-1:0] posterior_occupancy;
        logic              zero_denominator;
    } out_item_t;

    // Per-item control carried alongside the arithmetic.
    typedef struct packed {
        logic              vld;
        logic [1:0]        mode;
        logic [PROB_W-1:0] factor;
        logic [PROB_W-1:0] prior;
        logic              zero;
    } side_t;

    function automatic logic [PROB_W-1:0] sat_one(input logic [PROB_W-1:0] x);
        return (x > PROB_ONE) ? PROB_ONE : x;
    endfunction

    // Product of two fractions, rounded half up to PROB_FRAC_BITS bits.
    function automatic logic [PROB_W-1:0] fmul(input logic [PROB_W-1:0] a,
                                               input logic [PROB_W-1:0] b);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(a) * PROD_W'(b) + PROD_W'(PROB_HALF);
        return prod[PROB_FRAC_BITS +: PROB_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bayes_occupancy_update.sv -----
// ============================================================================
// bayes_occupancy_update: visibility-weighted Bayes occupancy update
// Streams voxel updates through a multiply, divide and blend pipeline and
// returns the clamped posterior occupancy of each voxel.
// ============================================================================
// Usage.
// The s_ channel takes one item per voxel: prior occupancy, visibility and
// measured factor, all unsigned Q1.16 with 65536 meaning one. The m_ channel
// returns one item per input item, in order: the posterior occupancy and a
// flag that is set when a Bayes denominator was zero, in which case the
// prior is returned unchanged. Configuration (hit probabilities and clamps)
// is written through the cfg_ channel, which is always ready, and should only
// be written while no items are in flight.
// On its way to m_valid an item passes four input, multiply and sum stages,
// seventeen divider stages (one quotient bit each), a blend multiply stage
// and the output register. Throughput is one item per cycle while the
// pipeline is not frozen, set by the pipelined dividers, which take a new
// division every enabled cycle. When the receiver stalls, the output register
// holds its item and a skid register catches the item behind it; only then
// does s_ready fall, and the whole pipeline freezes until the skid register
// drains. s_ready is driven straight from a register. Reset clears all valid
// bits and returns the configuration registers to their default values.
// ============================================================================
`default_nettype none

module bayes_occupancy_update (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bocc_pkg::in_item_t             s_data,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bocc_pkg::out_item_t                 m_data,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bocc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bocc_pkg::PROB_W-1:0]    cfg_data
);

    localparam int PW = bocc_pkg::PROB_W;
    localparam int FB = bocc_pkg::PROB_FRAC_BITS;
    localparam logic [PW-1:0] ONE = bocc_pkg::PROB_ONE;

    // ------------------------------------------------------------------
    // Configuration registers. Values above one are taken as one on use.
    // ------------------------------------------------------------------
    logic [PW-1:0] hit_occ_reg, hit_free_reg, hit_hid_reg, clamp_lo_reg, clamp_hi_reg;
    logic [PW-1:0] ho, hf, hh, lo, hi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_occ_reg  <= bocc_pkg::RST_HIT_IF_OCCUPIED;
            hit_free_reg <= bocc_pkg::RST_HIT_IF_FREE;
            hit_hid_reg  <= bocc_pkg::RST_HIT_IF_HIDDEN;
            clamp_lo_reg <= bocc_pkg::RST_CLAMP_LOW;
            clamp_hi_reg <= bocc_pkg::RST_CLAMP_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bocc_pkg::CFG_HIT_IF_OCCUPIED: hit_occ_reg  <= cfg_data;
                bocc_pkg::CFG_HIT_IF_FREE:     hit_free_reg <= cfg_data;
                bocc_pkg::CFG_HIT_IF_HIDDEN:   hit_hid_reg  <= cfg_data;
                bocc_pkg::CFG_CLAMP_LOW:       clamp_lo_reg <= cfg_data;
                bocc_pkg::CFG_CLAMP_HIGH:      clamp_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ho = bocc_pkg::sat_one(hit_occ_reg);
    assign hf = bocc_pkg::sat_one(hit_free_reg);
    assign hh = bocc_pkg::sat_one(hit_hid_reg);
    assign lo = bocc_pkg::sat_one(clamp_lo_reg);
    assign hi = bocc_pkg::sat_one(clamp_hi_reg);

    // ------------------------------------------------------------------
    // Pipeline enable. Every stage advances together while the skid
    // register is empty.
    // ------------------------------------------------------------------
    logic en;
    logic skid_vld_reg;
    logic s_acc;

    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign s_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 1: saturate the inputs and decide the update mode.
    // ------------------------------------------------------------------
    bocc_pkg::side_t s1_side_reg, s1_side_next;
    logic [PW-1:0]   s1_p_reg, s1_v_reg, p_in, v_in;

    always_comb begin
        p_in = bocc_pkg::sat_one(s_data.prior_occupancy);
        v_in = bocc_pkg::sat_one(s_data.visibility);
        s1_side_next.vld    = s_acc;
        s1_side_next.factor = bocc_pkg::sat_one(s_data.measured_factor);
        s1_side_next.prior  = s_data.prior_occupancy;
        s1_side_next.zero   = 1'b0;
        if (s1_side_next.factor == '0) begin
            s1_side_next.mode = bocc_pkg::MODE_MISS;
        end else if (s1_side_next.factor == ONE) begin
            s1_side_next.mode = bocc_pkg::MODE_HIT;
        end else begin
            s1_side_next.mode = bocc_pkg::MODE_BLEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_side_reg <= '0;
        end else if (en) begin
            s1_side_reg <= s1_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_p_reg <= p_in;
            s1_v_reg <= v_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: measurement probability times visibility, or its complement
    // for the hidden terms, for the hit and miss sets. A pure miss uses the
    // complement of hit_if_hidden; the blend keeps it for the miss posterior.
    // ------------------------------------------------------------------
    bocc_pkg::side_t s2_side_reg;
    logic [PW-1:0]   s2_p_reg;
    logic [PW-1:0]   s2_ov_h_reg, s2_hid_h_reg, s2_fv_h_reg;
    logic [PW-1:0]   s2_ov_m_reg, s2_hid_m_reg, s2_fv_m_reg;
    logic [PW-1:0]   mh_miss, not_v;

    assign mh_miss = (s1_side_reg.mode == bocc_pkg::MODE_MISS) ? (ONE - hh) : hh;
    assign not_v   = ONE - s1_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_side_reg <= '0;
        end else if (en) begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_p_reg     <= s1_p_reg;
            s2_ov_h_reg  <= bocc_pkg::fmul(ho, s1_v_reg);
            s2_hid_h_reg <= bocc_pkg::fmul(hh, not_v);
            s2_fv_h_reg  <= bocc_pkg::fmul(hf, s1_v_reg);
            s2_ov_m_reg  <= bocc_pkg::fmul(ONE - ho, s1_v_reg);
            s2_hid_m_reg <= bocc_pkg::fmul(mh_miss, not_v);
            s2_fv_m_reg  <= bocc_pkg::fmul(ONE - hf, s1_v_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the three-factor terms, each product rounded on its own.
    // ------------------------------------------------------------------
    bocc_pkg::side_t s3_side_reg;
    logic [PW-1:0]   s3_occ_h_reg, s3_hocc_h_reg, s3_free_h_reg, s3_hid_h_reg;
    logic [PW-1:0]   s3_occ_m_reg, s3_hocc_m_reg, s3_free_m_reg, s3_hid_m_reg;
    logic [PW-1:0]   not_p;

    assign not_p = ONE - s2_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_side_reg <= '0;
        end else if (en) begin
            s3_side_reg <= s2_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_occ_h_reg  <= bocc_pkg::fmul(s2_ov_h_reg, s2_p_reg);
            s3_hocc_h_reg <= bocc_pkg::fmul(s2_hid_h_reg, s2_p_reg);
            s3_free_h_reg <= bocc_pkg::fmul(s2_fv_h_reg, not_p);
            s3_hid_h_reg  <= s2_hid_h_reg;
            s3_occ_m_reg  <= bocc_pkg::fmul(s2_ov_m_reg, s2_p_reg);
            s3_hocc_m_reg <= bocc_pkg::fmul(s2_hid_m_reg, s2_p_reg);
            s3_free_m_reg <= bocc_pkg::fmul(s2_fv_m_reg, not_p);
            s3_hid_m_reg  <= s2_hid_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerators, denominators, rounded dividends and the
    // zero-denominator flag for whichever posteriors the mode needs.
    // ------------------------------------------------------------------
    bocc_pkg::side_t                s4_side_reg, s4_side_next;
    logic [bocc_pkg::DIVD_W-1:0]    s4_divd_h_reg, s4_divd_m_reg;
    logic [bocc_pkg::DEN_W-1:0]     s4_den_h_reg, s4_den_m_reg;
    logic [bocc_pkg::NUM_W-1:0]     num_h, num_m;
    logic [bocc_pkg::DEN_W-1:0]     den_h, den_m;

    assign num_h = bocc_pkg::NUM_W'(s3_occ_h_reg) + bocc_pkg::NUM_W'(s3_hocc_h_reg);
    assign num_m = bocc_pkg::NUM_W'(s3_occ_m_reg) + bocc_pkg::NUM_W'(s3_hocc_m_reg);
    assign den_h = bocc_pkg::DEN_W'(s3_occ_h_reg) + bocc_pkg::DEN_W'(s3_free_h_reg)
                 + bocc_pkg::DEN_W'(s3_hid_h_reg);
    assign den_m = bocc_pkg::DEN_W'(s3_occ_m_reg) + bocc_pkg::DEN_W'(s3_free_m_reg)
                 + bocc_pkg::DEN_W'(s3_hid_m_reg);

    always_comb begin
        s4_side_next = s3_side_reg;
        case (s3_side_reg.mode)
            bocc_pkg::MODE_MISS: s4_side_next.zero = (den_m == '0);
            bocc_pkg::MODE_HIT:  s4_side_next.zero = (den_h == '0);
            default:             s4_side_next.zero = (den_h == '0) || (den_m == '0);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_side_reg <= '0;
        end else if (en) begin
            s4_side_reg <= s4_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_divd_h_reg <= (bocc_pkg::DIVD_W'(num_h) << FB)
                           + bocc_pkg::DIVD_W'(den_h >> 1);
            s4_divd_m_reg <= (bocc_pkg::DIVD_W'(num_m) << FB)
                           + bocc_pkg::DIVD_W'(den_m >> 1);
            s4_den_h_reg  <= den_h;
            s4_den_m_reg  <= den_m;
        end
    end

    // ------------------------------------------------------------------
    // Dividers for the hit and miss posteriors, with the item's control
    // fields travelling in a matching delay line.
    // ------------------------------------------------------------------
    logic [bocc_pkg::QUO_W-1:0] quo_h, quo_m;
    bocc_pkg::side_t            dl_side_reg [0:bocc_pkg::DIV_LAT-1];

    bocc_div_pipe u_div_hit (
        .aclk     (aclk),
        .en       (en),
        .dividend (s4_divd_h_reg),
        .divisor  (s4_den_h_reg),
        .quotient (quo_h)
    );

    bocc_div_pipe u_div_miss (
        .aclk     (aclk),
        .en       (en),
        .dividend (s4_divd_m_reg),
        .divisor  (s4_den_m_reg),
        .quotient (quo_m)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bocc_pkg::DIV_LAT; i++) begin
                dl_side_reg[i] <= '0;
            end
        end else if (en) begin
            dl_side_reg[0] <= s4_side_reg;
            for (int i = 1; i < bocc_pkg::DIV_LAT; i++) begin
                dl_side_reg[i] <= dl_side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend stage: saturate both posteriors and form the weighted
    // products for the fractional mode.
    // ------------------------------------------------------------------
    bocc_pkg::side_t              b1_side_reg;
    logic [PW-1:0]                b1_hit_reg, b1_miss_reg, hit_sat, miss_sat, last_f;
    logic [bocc_pkg::PROD_W-1:0]  b1_ph_reg, b1_pm_reg;

    assign hit_sat  = bocc_pkg::sat_one(quo_h);
    assign miss_sat = bocc_pkg::sat_one(quo_m);
    assign last_f   = dl_side_reg[bocc_pkg::DIV_LAT-1].factor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_side_reg <= '0;
        end else if (en) begin
            b1_side_reg <= dl_side_reg[bocc_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_hit_reg  <= hit_sat;
            b1_miss_reg <= miss_sat;
            b1_ph_reg   <= bocc_pkg::PROD_W'(last_f) * bocc_pkg::PROD_W'(hit_sat);
            b1_pm_reg   <= bocc_pkg::PROD_W'(ONE - last_f) * bocc_pkg::PROD_W'(miss_sat);
        end
    end

    // ------------------------------------------------------------------
    // Final selection: clamp by mode, or pass the prior through when a
    // denominator was zero.
    // ------------------------------------------------------------------
    logic [bocc_pkg::BSUM_W-1:0] blend_sum;
    logic [bocc_pkg::BRES_W-1:0] blend, lo_w, hi_w;
    logic [PW-1:0]               res;
    bocc_pkg::out_item_t         tail_item;
    logic                        tail_vld;

    assign blend_sum = bocc_pkg::BSUM_W'(b1_ph_reg) + bocc_pkg::BSUM_W'(b1_pm_reg)
                     + bocc_pkg::BSUM_W'(bocc_pkg::PROB_HALF);
    assign blend     = blend_sum[FB +: bocc_pkg::BRES_W];
    assign lo_w      = bocc_pkg::BRES_W'(lo);
    assign hi_w      = bocc_pkg::BRES_W'(hi);

    always_comb begin
        case (b1_side_reg.mode)
            bocc_pkg::MODE_MISS: res = (b1_miss_reg > lo) ? b1_miss_reg : lo;
            bocc_pkg::MODE_HIT:  res = (b1_hit_reg < hi) ? b1_hit_reg : hi;
            default: begin
                // Lower clamp is tested first, so it wins for blends below it.
                if (blend < lo_w) begin
                    res = lo;
                end else if (blend > hi_w) begin
                    res = hi;
                end else begin
                    res = blend[PW-1:0];
                end
            end
        endcase
        tail_vld = b1_side_reg.vld;
        if (b1_side_reg.zero) begin
            tail_item.posterior_occupancy = b1_side_reg.prior;
            tail_item.zero_denominator    = 1'b1;
        end else begin
            tail_item.posterior_occupancy = res;
            tail_item.zero_denominator    = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register.
    // ------------------------------------------------------------------
    logic                out_vld_reg, out_vld_next, skid_vld_next;
    bocc_pkg::out_item_t out_item_reg, out_item_next, skid_item_reg, skid_item_next;

    always_comb begin
        out_vld_next   = out_vld_reg;
        out_item_next  = out_item_reg;
        skid_vld_next  = skid_vld_reg;
        skid_item_next = skid_item_reg;
        if (skid_vld_reg) begin
            // Pipeline is frozen; drain the skid item once the output moves.
            if (m_ready) begin
                out_item_next = skid_item_reg;
                skid_vld_next = 1'b0;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_vld_next  = tail_vld;
            out_item_next = tail_item;
        end else if (tail_vld) begin
            skid_vld_next  = 1'b1;
            skid_item_next = tail_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

`ifndef NO_ASSERTIONS
    // The skid register only ever holds an item behind a waiting output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register empty");

    // Input backpressure only starts after the output was held.
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready fell without an output stall");

    // A computed posterior never exceeds one.
    a_post_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.zero_denominator) |-> (m_data.posterior_occupancy <= ONE))
        else $error("posterior occupancy above one");
`endif

endmodule

`default_nettype wire

// ----- rtl/bocc_div_pipe.sv -----
// ============================================================================
// bocc_div_pipe: pipelined restoring divider
// Produces one quotient bit per stage; a new division may enter on every
// enabled cycle, and all stages advance together on the enable.
// ============================================================================
`default_nettype none

module bocc_div_pipe (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [bocc_pkg::DIVD_W-1:0] dividend,
    input  wire logic [bocc_pkg::DEN_W-1:0]  divisor,
    output logic      [bocc_pkg::QUO_W-1:0]  quotient
);

    localparam int QW = bocc_pkg::QUO_W;
    localparam int RW = bocc_pkg::DEN_W;
    localparam int DW = bocc_pkg::DIVD_W;

    logic [RW-1:0] rem_reg [0:QW-2];
    logic [QW-1:0] low_reg [0:QW-2];
    logic [RW-1:0] den_reg [0:QW-2];
    logic [QW-1:0] quo_reg [0:QW-1];

    logic [RW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] low_next [0:QW-1];
    logic [RW-1:0] den_next [0:QW-1];
    logic [QW-1:0] quo_next [0:QW-1];

    // The quotient is known to fit in QW bits, so the top part of the
    // dividend is already below the divisor and seeds the remainder.
    always_comb begin
        logic [RW-1:0] rin;
        logic [QW-1:0] lin;
        logic [RW-1:0] din;
        logic [QW-1:0] qin;
        logic [RW:0]   trial;
        logic          qbit;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                rin = RW'(dividend[DW-1:QW]);
                lin = dividend[QW-1:0];
                din = divisor;
                qin = '0;
            end else begin
                rin = rem_reg[s-1];
                lin = low_reg[s-1];
                din = den_reg[s-1];
                qin = quo_reg[s-1];
            end
            trial = {rin, lin[QW-1]};
            qbit  = (trial >= {1'b0, din});
            rem_next[s] = qbit ? RW'(trial - {1'b0, din}) : RW'(trial);
            low_next[s] = {lin[QW-2:0], 1'b0};
            den_next[s] = din;
            quo_next[s] = {qin[QW-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QW; s++) begin
                quo_reg[s] <= quo_next[s];
                if (s < QW - 1) begin
                    rem_reg[s] <= rem_next[s];
                    low_reg[s] <= low_next[s];
                    den_reg[s] <= den_next[s];
                end
            end
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

`default_nettype wire

// ----- verif/bayes_occupancy_update_test.sv -----
// ----------------------------------------------------------------------------
// bayes_occupancy_update_test: self-checking testbench for the occupancy update
// Drives voxel items into the block, predicts each posterior with an
// independent model of the visibility-weighted Bayes rule, and checks every
// returned item in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bayes_occupancy_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Q1.16 unit and half unit, held wide so that no intermediate overflows.
    localparam logic [63:0] UNIT = 64'd1 << bocc_pkg::PROB_FRAC_BITS;
    localparam logic [63:0] HALF_UNIT = UNIT >> 1;
    localparam int ONE_I = 1 << bocc_pkg::PROB_FRAC_BITS;
    localparam int PROB_MAX_I = (1 << bocc_pkg::PROB_W) - 1;
    localparam logic [bocc_pkg::PROB_W-1:0] P_ONE = bocc_pkg::PROB_W'(ONE_I);
    localparam logic [bocc_pkg::PROB_W-1:0] P_HALF = bocc_pkg::PROB_W'(ONE_I / 2);
    localparam logic [bocc_pkg::PROB_W-1:0] P_MAX = bocc_pkg::PROB_W'(PROB_MAX_I);
    // The final quiet period outlasts the block's latency with margin.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 150;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    bocc_pkg::in_item_t             s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    bocc_pkg::out_item_t            m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bocc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bocc_pkg::PROB_W-1:0]    cfg_data = '0;

    // Our own copy of the configuration registers.
    logic [bocc_pkg::PROB_W-1:0]  cur_hit_occ;
    logic [bocc_pkg::PROB_W-1:0]  cur_hit_free;
    logic [bocc_pkg::PROB_W-1:0]  cur_hit_hidden;
    logic [bocc_pkg::PROB_W-1:0]  cur_clamp_low;
    logic [bocc_pkg::PROB_W-1:0]  cur_clamp_high;

    // Posteriors still owed by the block, oldest first.
    bocc_pkg::out_item_t posterior_queue[$];
    int                  error_count = 0;
    // Idling percentages for the current phase.
    int                  tx_idle_pct = 0;
    int                  rx_stall_pct = 0;

    bayes_occupancy_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net: a correct run finishes far sooner than this.
    initial begin
        #2_000_000;
        $display("bayes_occupancy_update_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Anything above one is treated as exactly one.
    function automatic logic [63:0] clip_unit(input logic [63:0] x);
        return (x > UNIT) ? UNIT : x;
    endfunction

    // Fraction product, rounded half up back to Q1.16.
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + HALF_UNIT) >> bocc_pkg::PROB_FRAC_BITS;
    endfunction

    // Bayes posterior for one triple of measurement probabilities. Returns 0
    // when the denominator vanishes, in which case the ratio is meaningless.
    function automatic bit bayes_ratio(input logic [63:0] p, input logic [63:0] v,
                                       input logic [63:0] mo, input logic [63:0] mf,
                                       input logic [63:0] mh, output logic [63:0] ratio);
        logic [63:0] occ_vis;
        logic [63:0] hid;
        logic [63:0] hid_occ;
        logic [63:0] free_vis;
        logic [63:0] num;
        logic [63:0] den;
        occ_vis  = qmul(qmul(mo, v), p);
        hid      = qmul(mh, UNIT - v);
        hid_occ  = qmul(hid, p);
        free_vis = qmul(qmul(mf, v), UNIT - p);
        num      = occ_vis + hid_occ;
        den      = occ_vis + free_vis + hid;
        ratio    = '0;
        if (den == 0) begin
            return 1'b0;
        end
        ratio = clip_unit(((num << bocc_pkg::PROB_FRAC_BITS) + (den >> 1)) / den);
        return 1'b1;
    endfunction

    // Expected result for one voxel under the current configuration.
    function automatic bocc_pkg::out_item_t predict_posterior(input bocc_pkg::in_item_t it);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] f;
        logic [63:0] ho;
        logic [63:0] hf;
        logic [63:0] hh;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] hit;
        logic [63:0] miss;
        logic [63:0] r;
        bit          ok_hit;
        bit          ok_miss;
        bocc_pkg::out_item_t res;
        p  = clip_unit(64'(it.prior_occupancy));
        v  = clip_unit(64'(it.visibility));
        f  = clip_unit(64'(it.measured_factor));
        ho = clip_unit(64'(cur_hit_occ));
        hf = clip_unit(64'(cur_hit_free));
        hh = clip_unit(64'(cur_hit_hidden));
        lo = clip_unit(64'(cur_clamp_low));
        hi = clip_unit(64'(cur_clamp_high));
        hit = '0;
        miss = '0;
        ok_hit = 1'b1;
        ok_miss = 1'b1;
        if (f == 0) begin
            // Pure miss: complemented probabilities, clamped from below.
            ok_miss = bayes_ratio(p, v, UNIT - ho, UNIT - hf, UNIT - hh, miss);
            r = (miss > lo) ? miss : lo;
        end else if (f == UNIT) begin
            // Full hit: clamped from above.
            ok_hit = bayes_ratio(p, v, ho, hf, hh, hit);
            r = (hit < hi) ? hit : hi;
        end else begin
            // Blend. The miss side keeps the uncomplemented hidden term, and
            // the low clamp is tested first, so it wins for results below it.
            ok_hit  = bayes_ratio(p, v, ho, hf, hh, hit);
            ok_miss = bayes_ratio(p, v, UNIT - ho, UNIT - hf, hh, miss);
            r = (f * hit + (UNIT - f) * miss + HALF_UNIT) >> bocc_pkg::PROB_FRAC_BITS;
            if (r < lo) begin
                r = lo;
            end else if (r > hi) begin
                r = hi;
            end
        end
        if (ok_hit && ok_miss) begin
            res.posterior_occupancy = r[bocc_pkg::PROB_W-1:0];
            res.zero_denominator    = 1'b0;
        end else begin
            // The prior goes back untouched, even when it is above one.
            res.posterior_occupancy = it.prior_occupancy;
            res.zero_denominator    = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------------

    // Outputs are sampled at the edge, before any register updates, and the
    // ready for the next cycle is decided in the same pass.
    always @(posedge aclk) begin
        bocc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (posterior_queue.size() == 0) begin
                $error("unexpected item: posterior_occupancy %0d, zero_denominator %0d",
                       m_data.posterior_occupancy, m_data.zero_denominator);
                error_count++;
            end else begin
                want = posterior_queue.pop_front();
                if (m_data.posterior_occupancy !== want.posterior_occupancy) begin
                    $error("posterior_occupancy: expected %0d, got %0d",
                           want.posterior_occupancy, m_data.posterior_occupancy);
                    error_count++;
                end
                if (m_data.zero_denominator !== want.zero_denominator) begin
                    $error("zero_denominator: expected %0d, got %0d",
                           want.zero_denominator, m_data.zero_denominator);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic bocc_pkg::in_item_t voxel(input logic [bocc_pkg::PROB_W-1:0] p,
                                                 input logic [bocc_pkg::PROB_W-1:0] v,
                                                 input logic [bocc_pkg::PROB_W-1:0] f);
        bocc_pkg::in_item_t it;
        it.prior_occupancy = p;
        it.visibility      = v;
        it.measured_factor = f;
        return it;
    endfunction

    // A probability weighted towards the edges, with values above one too.
    function automatic logic [bocc_pkg::PROB_W-1:0] rand_prob();
        int unsigned sel;
        sel = $urandom_range(15);
        case (sel)
            0: return '0;
            1: return P_ONE;
            2: return bocc_pkg::PROB_W'($urandom_range(ONE_I + 1, PROB_MAX_I));
            3: return bocc_pkg::PROB_W'($urandom_range(0, PROB_MAX_I));
            default: return bocc_pkg::PROB_W'($urandom_range(0, ONE_I));
        endcase
    endfunction

    // A measured factor spread over the three modes.
    function automatic logic [bocc_pkg::PROB_W-1:0] rand_factor();
        int unsigned sel;
        sel = $urandom_range(11);
        case (sel)
            0, 1: return '0;
            2, 3: return P_ONE;
            4: return bocc_pkg::PROB_W'($urandom_range(ONE_I + 1, PROB_MAX_I));
            5: return ($urandom_range(1) != 0) ? bocc_pkg::PROB_W'(1)
                                               : bocc_pkg::PROB_W'(ONE_I - 1);
            default: return bocc_pkg::PROB_W'($urandom_range(1, ONE_I - 1));
        endcase
    endfunction

    // Writes one register. Valid is left high so that back-to-back writes
    // need no bubble; set_config lowers it when done.
    task automatic write_reg(input logic [bocc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bocc_pkg::PROB_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bocc_pkg::CFG_HIT_IF_OCCUPIED: cur_hit_occ    = val;
            bocc_pkg::CFG_HIT_IF_FREE:     cur_hit_free   = val;
            bocc_pkg::CFG_HIT_IF_HIDDEN:   cur_hit_hidden = val;
            bocc_pkg::CFG_CLAMP_LOW:       cur_clamp_low  = val;
            bocc_pkg::CFG_CLAMP_HIGH:      cur_clamp_high = val;
            default: ;
        endcase
    endtask

    // Writes every register, plus one write to an unused index that the
    // block must ignore. Only called once nothing is in flight.
    task automatic set_config(input logic [bocc_pkg::PROB_W-1:0] ho,
                              input logic [bocc_pkg::PROB_W-1:0] hf,
                              input logic [bocc_pkg::PROB_W-1:0] hh,
                              input logic [bocc_pkg::PROB_W-1:0] lo,
                              input logic [bocc_pkg::PROB_W-1:0] hi);
        write_reg(bocc_pkg::CFG_HIT_IF_OCCUPIED, ho);
        write_reg(bocc_pkg::CFG_HIT_IF_FREE, hf);
        write_reg(bocc_pkg::CFG_HIT_IF_HIDDEN, hh);
        write_reg(bocc_pkg::CFG_CLAMP_LOW, lo);
        write_reg(bocc_pkg::CFG_CLAMP_HIGH, hi);
        write_reg(bocc_pkg::CFG_IDX_W'($urandom_range(bocc_pkg::CFG_CLAMP_HIGH + 1,
                                                      (1 << bocc_pkg::CFG_IDX_W) - 1)),
                  bocc_pkg::PROB_W'($urandom_range(0, PROB_MAX_I)));
        cfg_valid <= 1'b0;
    endtask

    // Offers one item and holds it until accepted, then records its
    // expected posterior. Valid stays high unless a gap is rolled, so that
    // the next call can follow in the same time step without a bubble.
    task automatic send_voxel(input bocc_pkg::in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        posterior_queue = {posterior_queue, predict_posterior(it)};
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops sending and waits until every owed item has come back. Always
    // lets at least one edge pass, so valid is never lowered and raised in
    // one time step.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (posterior_queue.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and all three modes under the reset configuration.
    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_voxel(voxel('0, '0, '0));
        send_voxel(voxel(P_ONE, P_ONE, P_ONE));
        send_voxel(voxel(P_HALF, P_HALF, P_HALF));
        send_voxel(voxel(P_ONE, '0, '0));
        send_voxel(voxel('0, P_ONE, P_ONE));
        send_voxel(voxel(bocc_pkg::PROB_W'(12345), bocc_pkg::PROB_W'(50000),
                         bocc_pkg::PROB_W'(1)));
        send_voxel(voxel(bocc_pkg::PROB_W'(50000), bocc_pkg::PROB_W'(20000),
                         bocc_pkg::PROB_W'(ONE_I - 1)));
        // Fields above one are taken as one; a factor above one is a full hit.
        send_voxel(voxel(P_MAX, P_MAX, P_MAX));
        send_voxel(voxel(bocc_pkg::PROB_W'(ONE_I + 1), bocc_pkg::PROB_W'(40000),
                         bocc_pkg::PROB_W'(ONE_I + 1)));
        send_voxel(voxel(bocc_pkg::PROB_W'(30000), bocc_pkg::PROB_W'(ONE_I + 5), '0));
        wait_idle();
    endtask

    // Register extremes: zero denominators, registers above one and crossed
    // clamps.
    task automatic test_register_extremes();
        // Hits certain, misses impossible: a fully visible voxel with a zero
        // prior has nothing in the miss denominator.
        set_config(P_ONE, P_ONE, P_ONE, '0, P_ONE);
        send_voxel(voxel('0, P_ONE, '0));
        // The prior is passed through as given, above one included.
        send_voxel(voxel(P_MAX, P_ONE, '0));
        send_voxel(voxel('0, P_ONE, P_HALF));
        send_voxel(voxel(P_ONE, '0, P_ONE));
        wait_idle();

        // All registers zero: the hit denominator always vanishes.
        set_config('0, '0, '0, '0, '0);
        send_voxel(voxel(P_HALF, P_HALF, P_ONE));
        send_voxel(voxel(P_HALF, P_HALF, bocc_pkg::PROB_W'(20000)));
        send_voxel(voxel(bocc_pkg::PROB_W'(40000), bocc_pkg::PROB_W'(10000), '0));
        wait_idle();

        // Registers above one act as one.
        set_config(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX);
        send_voxel(voxel(bocc_pkg::PROB_W'(30000), bocc_pkg::PROB_W'(60000), P_ONE));
        send_voxel(voxel(bocc_pkg::PROB_W'(30000), bocc_pkg::PROB_W'(60000), '0));
        wait_idle();

        // Crossed clamps: the blend result is tested against the low clamp
        // first, so anything below it comes out as the low clamp.
        set_config(bocc_pkg::RST_HIT_IF_OCCUPIED, bocc_pkg::RST_HIT_IF_FREE,
                   bocc_pkg::RST_HIT_IF_HIDDEN,
                   bocc_pkg::PROB_W'(50000), bocc_pkg::PROB_W'(10000));
        send_voxel(voxel(bocc_pkg::PROB_W'(5000), bocc_pkg::PROB_W'(60000),
                         bocc_pkg::PROB_W'(1000)));
        send_voxel(voxel(bocc_pkg::PROB_W'(60000), bocc_pkg::PROB_W'(60000),
                         bocc_pkg::PROB_W'(64000)));
        send_voxel(voxel(P_HALF, P_HALF, '0));
        send_voxel(voxel(P_HALF, P_HALF, P_ONE));
        wait_idle();
    endtask

    // Random streams under random configurations, one phase per idling
    // pattern. Each phase starts from an idle block and ends drained.
    task automatic test_idle_phases();
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 67, 0, 13};
        rx_pct = '{0, 0, 67, 13};
        for (int ph = 0; ph < 4; ph++) begin
            if ($urandom_range(3) != 0) begin
                // Plausible sensor settings with ordered clamps.
                set_config(bocc_pkg::PROB_W'($urandom_range(ONE_I / 2, ONE_I)),
                           bocc_pkg::PROB_W'($urandom_range(0, ONE_I / 2)),
                           bocc_pkg::PROB_W'($urandom_range(0, ONE_I)),
                           bocc_pkg::PROB_W'($urandom_range(0, ONE_I / 4)),
                           bocc_pkg::PROB_W'($urandom_range(3 * ONE_I / 4, ONE_I)));
            end else begin
                set_config(rand_prob(), rand_prob(), rand_prob(), rand_prob(), rand_prob());
            end
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The sender now and then waits for the block to run dry.
                if ((ph == 1 && n == PHASE_ITEMS / 2) || $urandom_range(79) == 0) begin
                    wait_idle();
                end
                send_voxel(voxel(rand_prob(), rand_prob(), rand_factor()));
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        // The model starts from the register reset values.
        cur_hit_occ    = bocc_pkg::RST_HIT_IF_OCCUPIED;
        cur_hit_free   = bocc_pkg::RST_HIT_IF_FREE;
        cur_hit_hidden = bocc_pkg::RST_HIT_IF_HIDDEN;
        cur_clamp_low  = bocc_pkg::RST_CLAMP_LOW;
        cur_clamp_high = bocc_pkg::RST_CLAMP_HIGH;

        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_extremes();
        test_idle_phases();

        // Everything has returned; keep watching for stray items.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && posterior_queue.size() == 0) begin
            $display("bayes_occupancy_update_test: clean");
        end else begin
            $display("bayes_occupancy_update_test: errors");
        end
        $finish;
    end

endmodule
